[sv/ebc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types, codes and constants of the 8-bit processor core.
// ----------------------------------------------------------------------------
package ebc_pkg;

    // memory geometry
    localparam int ADDR_WIDTH = 16;
    localparam int MEM_DEPTH  = 1 << ADDR_WIDTH;
    localparam int REG_COUNT  = 8;

    // reset values of the configuration registers
    localparam logic [15:0] START_RESET = 16'hE000;
    localparam logic [15:0] STACK_RESET = 16'hFFFF;

    // flag bit positions
    localparam int FL_LESS  = 7;
    localparam int FL_EQUAL = 6;
    localparam int FL_CARRY = 5;
    localparam int FL_OVER  = 4;
    localparam int FL_ZERO  = 3;

    // request commands
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_EXEC = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // configuration register indexes
    localparam logic CFG_START_ADDRESS = 1'b0;
    localparam logic CFG_STACK_TOP     = 1'b1;

    // opcodes (top nibble of the instruction byte)
    localparam logic [3:0] OP_NOP  = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_ADC  = 4'h2;
    localparam logic [3:0] OP_AND  = 4'h3;
    localparam logic [3:0] OP_OR   = 4'h4;
    localparam logic [3:0] OP_NOT  = 4'h5;
    localparam logic [3:0] OP_CMP  = 4'h6;
    localparam logic [3:0] OP_LR   = 4'h7;
    localparam logic [3:0] OP_WR   = 4'h8;
    localparam logic [3:0] OP_JMP  = 4'h9;
    localparam logic [3:0] OP_JMF  = 4'hA;
    localparam logic [3:0] OP_SUB  = 4'hB;
    localparam logic [3:0] OP_PUSH = 4'hC;
    localparam logic [3:0] OP_POP  = 4'hD;
    localparam logic [3:0] OP_IP   = 4'hE;
    localparam logic [3:0] OP_OP   = 4'hF;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDATA,
        S_IR,
        S_CAP,
        S_RB,
        S_RBC,
        S_RL,
        S_RLC,
        S_EXEC,
        S_MEMRD,
        S_DONE
    } t_state;

endpackage

[sv/ebc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebc_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ebc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

[sv/eight_bit_cpu_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_cpu_core
// Small 8-bit processor with its own byte memory and register file.
// ----------------------------------------------------------------------------
// One request at a time: a load, a read or an instruction runs through the
// sequencer states (an instruction with a fetch for each operand byte,
// register lookups for a register-named operand and a further lookup for a
// second one, and a memory read for an indirect load or a pop), all set by the
// single port of the main memory and of the register RAM. After reset a
// clearing pass writes zero to every memory byte before the first request is
// taken; configuration writes are taken at any time.
module eight_bit_cpu_core
    import ebc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic [15:0]       i_address,
    input  logic [7:0]        i_data,
    input  logic [7:0]        i_in_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_read_data,
    output logic [15:0]       o_prog_counter,
    output logic [7:0]        o_flag_bits,
    output logic              o_out_valid,
    output logic signed [7:0] o_out_value,
    output logic              o_wants_input
);

    localparam int RW = $clog2(REG_COUNT);

    t_state r_state, n_state;
    logic [ADDR_WIDTH-1:0] r_clr, n_clr;
    logic [15:0] r_pc, n_pc, r_sp, n_sp, r_top;
    logic [7:0]  r_flags, n_flags;
    logic [7:0]  r_ir, n_ir, r_b0, n_b0, r_b1, n_b1, r_b2, n_b2;
    logic [1:0]  r_idx, n_idx, r_cnt, n_cnt;
    logic [7:0]  r_a, r_bi, n_bi, r_li, n_li, r_inv;
    logic        r_a_load;
    logic [7:0]  r_rd, n_rd, r_oval, n_oval;
    logic        r_ov, n_ov, r_wi, n_wi;
    logic        r_ovld;
    logic [7:0]  r_o_rd, r_o_flags, r_o_oval;
    logic [15:0] r_o_pc;
    logic        r_o_ov, r_o_wi;

    logic                  mem_we, reg_we;
    logic [ADDR_WIDTH-1:0] mem_addr;
    logic [7:0]            mem_wdata, mem_rdata, reg_wdata, reg_rdata;
    logic [RW-1:0]         reg_addr;
    logic                  accept;

    // exec datapath
    logic [7:0]  ex_a, ex_b, ex_nb, ex_sub, ex_lo, ex_v;
    logic [8:0]  ex_sum;
    logic [15:0] ex_base;
    logic        jmf_taken;

    // main memory and register file
    ebc_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    ebc_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_regs (
        .i_clk  (i_clk),
        .i_we   (reg_we),
        .i_addr (reg_addr),
        .i_wdata(reg_wdata),
        .o_rdata(reg_rdata)
    );

    // operand byte count of an instruction
    function automatic logic [1:0] f_count(input logic [7:0] ir, input logic [7:0] fl);
        logic [1:0] c;
        c = 2'd0;
        case (ir[7:4])
            OP_ADD, OP_ADC, OP_AND, OP_OR, OP_CMP, OP_SUB: c = 2'd1;
            OP_LR:   c = ir[3] ? 2'd2 : 2'd1;
            OP_WR:   c = 2'd3;
            OP_JMP:  c = 2'd2;
            OP_JMF:  c = fl[3'd7 - ir[2:0]] ? 2'd2 : 2'd0;
            OP_PUSH: c = ir[3] ? 2'd0 : 2'd1;
            OP_OP:   c = ir[3] ? 2'd0 : 2'd1;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    // register-named value operand
    function automatic logic f_need_bi(input logic [7:0] ir);
        logic n;
        n = 1'b0;
        case (ir[7:4])
            OP_ADD, OP_ADC, OP_AND, OP_OR, OP_CMP, OP_SUB, OP_WR: n = ir[3];
            default: n = 1'b0;
        endcase
        return n;
    endfunction

    // register-named low address byte of a write
    function automatic logic f_need_li(input logic [7:0] ir);
        return (ir[7:4] == OP_WR) && ir[0];
    endfunction

    function automatic t_state f_after_ops(input logic [7:0] ir);
        t_state s;
        if (f_need_bi(ir)) begin
            s = S_RB;
        end else if (f_need_li(ir)) begin
            s = S_RL;
        end else begin
            s = S_EXEC;
        end
        return s;
    endfunction

    function automatic logic f_ovf(input logic [7:0] x, input logic [7:0] y,
                                   input logic [7:0] s);
        return (x[7] == y[7]) && (s[7] != x[7]);
    endfunction

    assign o_ready = (r_state == S_IDLE) && !r_ovld;
    assign accept  = i_valid && o_ready;

    // exec operands
    assign ex_a      = r_a_load ? reg_rdata : r_a;
    assign ex_b      = r_ir[3] ? r_bi : r_b0;
    assign ex_sum    = {1'b0, ex_a} + {1'b0, ex_b};
    assign ex_nb     = ~ex_b + 8'd1;
    assign ex_sub    = ex_a + ex_nb;
    assign ex_lo     = r_ir[0] ? r_li : r_b2;
    assign ex_v      = r_ir[3] ? r_bi : r_b0;
    assign jmf_taken = r_flags[3'd7 - r_ir[2:0]];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_EXEC: n_state = S_IR;
                        CMD_READ: n_state = S_RDATA;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_RDATA: n_state = S_DONE;
            S_IR: begin
                if (f_count(mem_rdata, r_flags) != 2'd0) begin
                    n_state = S_CAP;
                end else begin
                    n_state = f_after_ops(mem_rdata);
                end
            end
            S_CAP: begin
                if (2'(r_idx + 2'd1) == r_cnt) n_state = f_after_ops(r_ir);
            end
            S_RB:  n_state = S_RBC;
            S_RBC: n_state = f_need_li(r_ir) ? S_RLC : S_EXEC;
            S_RL:  n_state = S_RLC;
            S_RLC: n_state = S_EXEC;
            S_EXEC: begin
                if (((r_ir[7:4] == OP_LR) && r_ir[3]) ||
                    ((r_ir[7:4] == OP_POP) && (r_sp != r_top))) begin
                    n_state = S_MEMRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MEMRD: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pc[ADDR_WIDTH-1:0];
        mem_wdata = 8'd0;
        reg_we    = 1'b0;
        reg_addr  = r_ir[RW-1:0];
        reg_wdata = 8'd0;
        n_clr   = r_clr;
        n_pc    = r_pc;
        n_sp    = r_sp;
        n_flags = r_flags;
        n_ir    = r_ir;
        n_b0    = r_b0;
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_bi    = r_bi;
        n_li    = r_li;
        n_rd    = r_rd;
        n_ov    = r_ov;
        n_oval  = r_oval;
        n_wi    = r_wi;
        ex_base = r_pc;
        case (r_state)
            // zero both memories after reset
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                reg_we   = 1'b1;
                reg_addr = r_clr[RW-1:0];
                n_clr    = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    n_rd   = 8'd0;
                    n_ov   = 1'b0;
                    n_oval = 8'd0;
                    n_wi   = 1'b0;
                    case (i_cmd)
                        CMD_LOAD: begin
                            mem_we    = 1'b1;
                            mem_addr  = i_address[ADDR_WIDTH-1:0];
                            mem_wdata = i_data;
                        end
                        CMD_READ: mem_addr = i_address[ADDR_WIDTH-1:0];
                        default:  mem_addr = r_pc[ADDR_WIDTH-1:0];
                    endcase
                end
            end
            S_RDATA: n_rd = mem_rdata;
            // instruction byte in, read first register, fetch first operand
            S_IR: begin
                n_ir     = mem_rdata;
                reg_addr = mem_rdata[RW-1:0];
                n_cnt    = f_count(mem_rdata, r_flags);
                n_idx    = 2'd0;
                if (n_cnt != 2'd0) begin
                    n_pc     = r_pc + 16'd1;
                    mem_addr = n_pc[ADDR_WIDTH-1:0];
                end
            end
            // operand bytes, next fetch overlapped
            S_CAP: begin
                case (r_idx)
                    2'd0:    n_b0 = mem_rdata;
                    2'd1:    n_b1 = mem_rdata;
                    default: n_b2 = mem_rdata;
                endcase
                n_idx = r_idx + 2'd1;
                if (n_idx != r_cnt) begin
                    n_pc     = r_pc + 16'd1;
                    mem_addr = n_pc[ADDR_WIDTH-1:0];
                end
            end
            S_RB: reg_addr = r_b0[RW-1:0];
            S_RBC: begin
                n_bi     = reg_rdata;
                reg_addr = r_b2[RW-1:0];
            end
            S_RL:  reg_addr = r_b2[RW-1:0];
            S_RLC: n_li = reg_rdata;
            S_EXEC: begin
                reg_addr = r_ir[RW-1:0];
                case (r_ir[7:4])
                    OP_ADD: begin
                        n_flags[FL_OVER]  = f_ovf(ex_a, ex_b, ex_sum[7:0]);
                        n_flags[FL_CARRY] = ex_sum[8];
                        reg_we    = 1'b1;
                        reg_wdata = ex_sum[7:0];
                    end
                    OP_ADC: begin
                        reg_we    = 1'b1;
                        reg_wdata = ex_sum[7:0] + {7'd0, r_flags[FL_CARRY]};
                        n_flags[FL_CARRY] = 1'b0;
                    end
                    OP_AND: begin
                        reg_we    = 1'b1;
                        reg_wdata = ex_a & ex_b;
                    end
                    OP_OR: begin
                        reg_we    = 1'b1;
                        reg_wdata = ex_a | ex_b;
                    end
                    OP_NOT: begin
                        reg_we    = 1'b1;
                        reg_wdata = ~ex_a;
                    end
                    OP_CMP: begin
                        n_flags[FL_EQUAL] = (ex_a == ex_b);
                        n_flags[FL_LESS]  = ($signed(ex_a) < $signed(ex_b));
                        n_flags[FL_ZERO]  = (ex_a == 8'd0);
                    end
                    OP_LR: begin
                        if (r_ir[3]) begin
                            mem_addr = 16'({r_b0, r_b1});
                        end else begin
                            reg_we    = 1'b1;
                            reg_wdata = r_b0;
                        end
                    end
                    OP_WR: begin
                        mem_we    = 1'b1;
                        mem_addr  = 16'({r_b1, ex_lo});
                        mem_wdata = ex_v;
                    end
                    OP_JMP: ex_base = {r_b0, r_b1};
                    OP_JMF: ex_base = jmf_taken ? {r_b0, r_b1} : r_pc + 16'd2;
                    OP_SUB: begin
                        n_flags[FL_OVER] = f_ovf(ex_a, ex_nb, ex_sub);
                        reg_we    = 1'b1;
                        reg_wdata = ex_sub;
                    end
                    OP_PUSH: begin
                        mem_we    = 1'b1;
                        mem_addr  = r_sp[ADDR_WIDTH-1:0];
                        mem_wdata = r_ir[3] ? ex_a : r_b0;
                        n_sp      = r_sp - 16'd1;
                    end
                    OP_POP: begin
                        if (r_sp != r_top) begin
                            n_sp     = r_sp + 16'd1;
                            mem_addr = n_sp[ADDR_WIDTH-1:0];
                        end
                    end
                    OP_IP: begin
                        reg_we    = 1'b1;
                        reg_wdata = r_inv;
                        n_wi      = 1'b1;
                    end
                    OP_OP: begin
                        if (r_ir[3]) begin
                            n_ov   = 1'b1;
                            n_oval = ex_a;
                        end else begin
                            ex_base = r_pc + {8'd0, r_b0};
                        end
                    end
                    default: ;
                endcase
                n_pc = ex_base + 16'd1;
            end
            // indirect load or pop data into the register
            S_MEMRD: begin
                reg_we    = 1'b1;
                reg_addr  = r_ir[RW-1:0];
                reg_wdata = mem_rdata;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pc     <= START_RESET;
            r_sp     <= STACK_RESET;
            r_top    <= STACK_RESET;
            r_flags  <= 8'd0;
            r_a_load <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_flags  <= n_flags;
            r_a_load <= (r_state == S_IR);
            if (r_state == S_DONE) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
            // program counter and stack pointer, also loaded by configuration writes
            if (i_cfg_we && (i_cfg_index == CFG_START_ADDRESS)) begin
                r_pc <= i_cfg_data;
            end else begin
                r_pc <= n_pc;
            end
            if (i_cfg_we && (i_cfg_index == CFG_STACK_TOP)) begin
                r_top <= i_cfg_data;
                r_sp  <= i_cfg_data;
            end else begin
                r_sp <= n_sp;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ir   <= n_ir;
        r_b0   <= n_b0;
        r_b1   <= n_b1;
        r_b2   <= n_b2;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_bi   <= n_bi;
        r_li   <= n_li;
        r_rd   <= n_rd;
        r_ov   <= n_ov;
        r_oval <= n_oval;
        r_wi   <= n_wi;
        if (r_a_load) r_a <= reg_rdata;
        if (accept) r_inv <= i_in_value;
        if (r_state == S_DONE) begin
            r_o_rd    <= r_rd;
            r_o_pc    <= r_pc;
            r_o_flags <= r_flags;
            r_o_ov    <= r_ov;
            r_o_oval  <= r_oval;
            r_o_wi    <= r_wi;
        end
    end

    // result outputs
    assign o_valid        = r_ovld;
    assign o_read_data    = r_o_rd;
    assign o_prog_counter = r_o_pc;
    assign o_flag_bits    = r_o_flags;
    assign o_out_valid    = r_o_ov;
    assign o_out_value    = $signed(r_o_oval);
    assign o_wants_input  = r_o_wi;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the 8-bit processor core: memory load/read requests and execution
// of every opcode, compared against an in-bench instruction-level predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import ebc_pkg::*;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] prog_counter;
        logic [7:0]  flag_bits;
        logic        out_valid;
        logic [7:0]  out_value;
        logic        wants_input;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [15:0]       i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_cmd;
    logic [15:0]       i_address;
    logic [7:0]        i_data;
    logic [7:0]        i_in_value;
    logic              o_valid;
    logic              i_ready;
    logic [7:0]        o_read_data;
    logic [15:0]       o_prog_counter;
    logic [7:0]        o_flag_bits;
    logic              o_out_valid;
    logic signed [7:0] o_out_value;
    logic              o_wants_input;

    eight_bit_cpu_core dut (.*);

    // predictor state
    logic [7:0]  pm_mem [0:MEM_DEPTH-1];
    logic [7:0]  pm_regs [0:REG_COUNT-1];
    logic [15:0] pm_pc;
    logic [15:0] pm_sp;
    logic [7:0]  pm_flags;
    logic [15:0] pm_stack_top;

    t_result expected_results [$];
    int      n_errors;
    int      n_checked;
    int      n_sent;
    int      sender_idle_pct;
    int      receiver_idle_pct;
    bit      hold_off;
    longint  cycle_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAIL eight_bit_cpu_core");
                $finish;
            end
        end
    end

    function automatic logic [7:0] fetch_next();
        pm_pc = pm_pc + 16'd1;
        return pm_mem[pm_pc];
    endfunction

    function automatic logic [7:0] fetch_operand(logic [7:0] ir);
        logic [7:0] b;
        b = fetch_next();
        if (ir[3]) b = pm_regs[b[2:0]];
        return b;
    endfunction

    function automatic logic [15:0] fetch_addr();
        logic [7:0] hi;
        logic [7:0] lo;
        hi = fetch_next();
        lo = fetch_next();
        return {hi, lo};
    endfunction

    // instruction-level prediction of one request
    function automatic t_result predict_request(logic [1:0] cmd, logic [15:0] addr,
                                                logic [7:0] data, logic [7:0] inv);
        t_result     res;
        logic [7:0]  ir;
        logic [2:0]  r;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  v;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [8:0]  wide;
        int          s;
        res = '0;
        if (cmd == CMD_LOAD) begin
            pm_mem[addr] = data;
        end else if (cmd == CMD_READ) begin
            res.read_data = pm_mem[addr];
        end else if (cmd == CMD_EXEC) begin
            ir = pm_mem[pm_pc];
            r  = ir[2:0];
            a  = pm_regs[r];
            case (ir[7:4])
                OP_ADD: begin
                    b = fetch_operand(ir);
                    s = $signed(a) + $signed(b);
                    pm_flags[FL_OVER] = (s > 127 || s < -128);
                    wide = a + b;
                    pm_flags[FL_CARRY] = wide[8];
                    pm_regs[r] = wide[7:0];
                end
                OP_ADC: begin
                    b = fetch_operand(ir);
                    pm_regs[r] = a + b + {7'd0, pm_flags[FL_CARRY]};
                    pm_flags[FL_CARRY] = 1'b0;
                end
                OP_AND: begin
                    b = fetch_operand(ir);
                    pm_regs[r] = a & b;
                end
                OP_OR: begin
                    b = fetch_operand(ir);
                    pm_regs[r] = a | b;
                end
                OP_NOT: pm_regs[r] = ~a;
                OP_CMP: begin
                    b = fetch_operand(ir);
                    pm_flags[FL_EQUAL] = (a == b);
                    pm_flags[FL_LESS]  = ($signed(a) < $signed(b));
                    pm_flags[FL_ZERO]  = (a == 8'd0);
                end
                OP_LR: begin
                    if (ir[3]) pm_regs[r] = pm_mem[fetch_addr()];
                    else pm_regs[r] = fetch_next();
                end
                OP_WR: begin
                    v = fetch_next();
                    if (ir[3]) v = pm_regs[v[2:0]];
                    hi = fetch_next();
                    lo = fetch_next();
                    if (ir[0]) lo = pm_regs[lo[2:0]];
                    pm_mem[{hi, lo}] = v;
                end
                OP_JMP: pm_pc = fetch_addr();
                OP_JMF: begin
                    if (pm_flags[3'd7 - r]) pm_pc = fetch_addr();
                    else pm_pc = pm_pc + 16'd2;
                end
                OP_SUB: begin
                    b = fetch_operand(ir);
                    v = 8'd0 - b;
                    s = $signed(a) + $signed(v);
                    pm_flags[FL_OVER] = (s > 127 || s < -128);
                    pm_regs[r] = a + v;
                end
                OP_PUSH: begin
                    b = ir[3] ? a : fetch_next();
                    pm_mem[pm_sp] = b;
                    pm_sp = pm_sp - 16'd1;
                end
                OP_POP: begin
                    if (pm_sp != pm_stack_top) begin
                        pm_sp = pm_sp + 16'd1;
                        pm_regs[r] = pm_mem[pm_sp];
                    end
                end
                OP_IP: begin
                    pm_regs[r] = inv;
                    res.wants_input = 1'b1;
                end
                OP_OP: begin
                    if (ir[3]) begin
                        res.out_valid = 1'b1;
                        res.out_value = a;
                    end else begin
                        b = fetch_next();
                        pm_pc = pm_pc + {8'd0, b};
                    end
                end
                default: ;
            endcase
            pm_pc = pm_pc + 16'd1;
        end
        res.prog_counter = pm_pc;
        res.flag_bits    = pm_flags;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_checked);
        n_errors++;
    endtask

    // send one request and record its prediction at acceptance
    task automatic send_request(logic [1:0] cmd, logic [15:0] addr,
                                logic [7:0] data, logic [7:0] inv);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_address  <= addr;
        i_data     <= data;
        i_in_value <= inv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(predict_request(cmd, addr, data, inv));
        n_sent++;
    endtask

    task automatic load_byte(logic [15:0] addr, logic [7:0] data);
        send_request(CMD_LOAD, addr, data, 8'($urandom));
    endtask

    task automatic exec_one(logic [7:0] inv);
        send_request(CMD_EXEC, 16'($urandom), 8'($urandom), inv);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_config(logic idx, logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_START_ADDRESS) begin
            pm_pc = value;
        end else begin
            pm_stack_top = value;
            pm_sp        = value;
        end
    endtask

    // place a program of bytes at the program counter onward
    task automatic load_program(logic [7:0] prog [$]);
        logic [15:0] at;
        at = pm_pc;
        foreach (prog[i]) begin
            load_byte(at, prog[i]);
            at = at + 16'd1;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result at cycle %0d", cycle_count);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", o_read_data, want.read_data);
                if (o_prog_counter !== want.prog_counter)
                    report_mismatch("prog_counter", o_prog_counter, want.prog_counter);
                if (o_flag_bits !== want.flag_bits)
                    report_mismatch("flag_bits", o_flag_bits, want.flag_bits);
                if (o_out_valid !== want.out_valid)
                    report_mismatch("out_valid", o_out_valid, want.out_valid);
                if (o_out_value !== want.out_value)
                    report_mismatch("out_value", o_out_value, want.out_value);
                if (o_wants_input !== want.wants_input)
                    report_mismatch("wants_input", o_wants_input, want.wants_input);
                n_checked++;
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !hold_off && ($urandom_range(99) >= receiver_idle_pct);
    end

    // long receiver hold-off while requests keep coming
    task automatic hold_receiver();
        hold_off = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    // directed: a program holding every opcode, placed at the current program counter
    task automatic test_opcodes();
        logic [7:0] prog [$];
        // lr r0,#7f ; lr r1,#01 ; add r0,r1 -> overflow ; add r1,#ff -> carry ; adc r1,#00
        prog = '{8'h70, 8'h7f, 8'h71, 8'h01, 8'h18, 8'h01, 8'h11, 8'hff, 8'h21, 8'h00,
                 8'h32, 8'h0f, 8'h42, 8'hf0, 8'h53, 8'h60, 8'h80, 8'h68, 8'h01,
                 8'hb4, 8'h80, 8'hc7, 8'h5a, 8'hcf, 8'hd5, 8'hd6, 8'he2, 8'hfa,
                 8'hf0, 8'h01, 8'h00, 8'h7d, 8'h12, 8'h34, 8'h88, 8'h02, 8'h12,
                 8'h34, 8'h89, 8'h03, 8'h12, 8'h02, 8'hab, 8'h00, 8'h00, 8'ha0,
                 8'h00, 8'h00, 8'h90, 8'he0, 8'h00};
        load_program(prog);
        repeat (26) exec_one(8'($urandom));
        send_request(CMD_READ, 16'h1234, 8'h00, 8'h00);
        send_request(CMD_READ, 16'hffff, 8'h00, 8'h00);
        send_request(2'd3, 16'h0000, 8'h00, 8'h00);
    endtask

    // random instruction streams with random operands
    task automatic test_random_programs(int count);
        logic [7:0] prog [$];
        int         len;
        int         done;
        done = 0;
        while (done < count) begin
            prog = {};
            len = $urandom_range(1, 6);
            for (int i = 0; i < len * 4; i++) prog.push_back(8'($urandom));
            // turn most jumps into no-ops so programs mostly stay in loaded bytes
            for (int i = 0; i < prog.size(); i += 4)
                if (prog[i][7:4] == OP_JMP && $urandom_range(3) != 0) prog[i] = 8'h00;
            load_program(prog);
            for (int i = 0; i < len; i++) exec_one(8'($urandom));
            if ($urandom_range(3) == 0)
                send_request(CMD_READ, pm_sp + 16'd1, 8'h00, 8'h00);
            if ($urandom_range(7) == 0)
                send_request(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            done += prog.size() + len;
        end
    endtask

    initial begin
        n_errors = 0;
        n_checked = 0;
        n_sent = 0;
        hold_off = 1'b0;
        sender_idle_pct = 14;
        receiver_idle_pct = 58;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_START_ADDRESS;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_cmd = CMD_LOAD;
        i_address = '0;
        i_data = '0;
        i_in_value = '0;
        foreach (pm_mem[i]) pm_mem[i] = 8'h00;
        foreach (pm_regs[i]) pm_regs[i] = 8'h00;
        pm_stack_top = STACK_RESET;
        pm_pc = START_RESET;
        pm_sp = STACK_RESET;
        pm_flags = 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_opcodes();
        test_random_programs(130);
        wait_drain();
        write_config(CFG_START_ADDRESS, 16'h0000);
        write_config(CFG_STACK_TOP, 16'h8000);
        sender_idle_pct = 58;
        receiver_idle_pct = 14;
        fork
            hold_receiver();
            test_random_programs(130);
        join
        wait_drain();
        write_config(CFG_START_ADDRESS, 16'hfff0);
        write_config(CFG_STACK_TOP, 16'h0000);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random_programs(130);
        wait_drain();

        $display("covered %0d requests, %0d results checked, all opcodes,", n_sent, n_checked);
        $display("three config settings and a long output stall");
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("PASS eight_bit_cpu_core");
        end else begin
            $display("FAIL eight_bit_cpu_core");
        end
        $finish;
    end

endmodule

[files.f]
sv/ebc_pkg.sv
sv/ebc_ram.sv
sv/eight_bit_cpu_core.sv
sim/tb_top.sv
